// ===== design/mtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Map text tokenizer package
// Shared constants: default widths, token kinds and the character codes that
// the lexer recognizes.
// ----------------------------------------------------------------------------
package mtt_pkg;

	localparam int OFFSET_WIDTH_DEF = 24;
	localparam int LINE_WIDTH_DEF   = 20;

	localparam logic [1:0] TOK_SYMBOL = 2'd0;
	localparam logic [1:0] TOK_STRING = 2'd1;
	localparam logic [1:0] TOK_WORD   = 2'd2;
	localparam logic [1:0] TOK_END    = 2'd3;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;

endpackage

// ===== design/mtt_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Map text tokenizer lexer stage
// Holds the accepted request in an input register and the scan state, and
// produces up to two packed tokens per request for the result queue.
// ----------------------------------------------------------------------------
module mtt_lexer #(
	parameter int OFFSET_WIDTH = mtt_pkg::OFFSET_WIDTH_DEF,
	parameter int LINE_WIDTH   = mtt_pkg::LINE_WIDTH_DEF,
	parameter int RES_W        = 2 * OFFSET_WIDTH + LINE_WIDTH + 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_end,
	input  logic [7:0]       in_byte,
	input  logic             room,
	output logic [1:0]       push_n,
	output logic [RES_W-1:0] push_d0,
	output logic [RES_W-1:0] push_d1
);

	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'd0,
		MODE_SLASH   = 3'd1,
		MODE_COMMENT = 3'd2,
		MODE_STRING  = 3'd3,
		MODE_WORD    = 3'd4
	} mode_t;

	logic                    valid_s1;
	logic                    end_s1;
	logic [7:0]              byte_s1;
	logic                    adv;

	mode_t                   mode_q, mode_d;
	logic [OFFSET_WIDTH-1:0] pos_q, pos_d, pstart_q, pstart_d;
	logic [LINE_WIDTH-1:0]   line_q, line_d, pline_q, pline_d;

	logic                    is_sp, is_sym, is_nl, is_quote, is_slash;
	logic [OFFSET_WIDTH-1:0] pos_inc, plen;
	logic [LINE_WIDTH-1:0]   line_inc;
	logic                    do_between;

	logic [1:0]              n;
	logic [1:0]              r0_kind, r1_kind;
	logic [OFFSET_WIDTH-1:0] r0_start, r1_start, r0_len, r1_len;
	logic [LINE_WIDTH-1:0]   r0_line, r1_line;
	logic [7:0]              r0_sym, r1_sym;

	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			end_s1  <= in_end;
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BETWEEN;
			pos_q    <= '0;
			line_q   <= LINE_WIDTH'(1);
			pstart_q <= '0;
			pline_q  <= LINE_WIDTH'(1);
		end else if (adv) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			line_q   <= line_d;
			pstart_q <= pstart_d;
			pline_q  <= pline_d;
		end
	end

	always_comb begin
		is_nl    = (byte_s1 == mtt_pkg::CH_LF);
		is_sp    = (byte_s1 == mtt_pkg::CH_SPACE) || (byte_s1 == mtt_pkg::CH_TAB) ||
			(byte_s1 == mtt_pkg::CH_CR) || is_nl;
		is_sym   = (byte_s1 == mtt_pkg::CH_LBRACE) || (byte_s1 == mtt_pkg::CH_RBRACE) ||
			(byte_s1 == mtt_pkg::CH_LPAREN) || (byte_s1 == mtt_pkg::CH_RPAREN) ||
			(byte_s1 == mtt_pkg::CH_LBRACK) || (byte_s1 == mtt_pkg::CH_RBRACK);
		is_quote = (byte_s1 == mtt_pkg::CH_QUOTE);
		is_slash = (byte_s1 == mtt_pkg::CH_SLASH);
		pos_inc  = (pos_q != '1) ? pos_q + OFFSET_WIDTH'(1) : pos_q;
		line_inc = (line_q != '1) ? line_q + LINE_WIDTH'(1) : line_q;
		plen     = (pos_q >= pstart_q) ? pos_q - pstart_q : '0;
	end

	always_comb begin
		mode_d     = mode_q;
		pos_d      = pos_inc;
		line_d     = line_q;
		pstart_d   = pstart_q;
		pline_d    = pline_q;
		do_between = 1'b0;
		n          = 2'd0;
		r0_kind    = mtt_pkg::TOK_WORD;
		r0_start   = pstart_q;
		r0_len     = plen;
		r0_line    = pline_q;
		r0_sym     = '0;
		r1_kind    = mtt_pkg::TOK_END;
		r1_start   = pos_q;
		r1_len     = '0;
		r1_line    = line_q;
		r1_sym     = '0;

		if (end_s1) begin
			if (mode_q == MODE_SLASH || mode_q == MODE_WORD || mode_q == MODE_STRING) begin
				r0_kind = (mode_q == MODE_STRING) ? mtt_pkg::TOK_STRING : mtt_pkg::TOK_WORD;
				n       = 2'd2;
			end else begin
				r0_kind  = mtt_pkg::TOK_END;
				r0_start = pos_q;
				r0_len   = '0;
				r0_line  = line_q;
				n        = 2'd1;
			end
			mode_d   = MODE_BETWEEN;
			pos_d    = '0;
			line_d   = LINE_WIDTH'(1);
			pstart_d = '0;
			pline_d  = LINE_WIDTH'(1);
		end else begin
			case (mode_q)
				MODE_SLASH, MODE_WORD: begin
					if (mode_q == MODE_SLASH && is_slash) begin
						mode_d = MODE_COMMENT;
					end else if (is_sp || is_sym) begin
						n          = 2'd1;
						do_between = 1'b1;
					end else begin
						mode_d = MODE_WORD;
					end
				end
				MODE_COMMENT: begin
					do_between = is_nl;
				end
				MODE_STRING: begin
					if (is_quote) begin
						r0_kind = mtt_pkg::TOK_STRING;
						n       = 2'd1;
						mode_d  = MODE_BETWEEN;
					end else if (is_nl) begin
						line_d = line_inc;
					end
				end
				default: begin
					do_between = 1'b1;
				end
			endcase

			if (do_between) begin
				mode_d = MODE_BETWEEN;
				if (is_sp) begin
					if (is_nl) begin
						line_d = line_inc;
					end
				end else if (is_sym) begin
					if (n == 2'd0) begin
						r0_kind  = mtt_pkg::TOK_SYMBOL;
						r0_start = pos_q;
						r0_len   = OFFSET_WIDTH'(1);
						r0_line  = line_q;
						r0_sym   = byte_s1;
						n        = 2'd1;
					end else begin
						r1_kind  = mtt_pkg::TOK_SYMBOL;
						r1_len   = OFFSET_WIDTH'(1);
						r1_sym   = byte_s1;
						n        = 2'd2;
					end
				end else if (is_quote) begin
					pstart_d = pos_inc;
					pline_d  = line_q;
					mode_d   = MODE_STRING;
				end else begin
					pstart_d = pos_q;
					pline_d  = line_q;
					mode_d   = is_slash ? MODE_SLASH : MODE_WORD;
				end
			end
		end
	end

	assign push_n  = adv ? n : 2'd0;
	assign push_d0 = {(n == 2'd1), r0_sym, r0_line, r0_len, r0_start, r0_kind};
	assign push_d1 = {1'b1, r1_sym, r1_line, r1_len, r1_start, r1_kind};

endmodule

// ===== design/mtt_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Map text tokenizer result queue
// Four-entry queue that takes up to two tokens per cycle and hands out one.
// ----------------------------------------------------------------------------
module mtt_result_fifo #(
	parameter int RES_W = 2 * mtt_pkg::OFFSET_WIDTH_DEF + mtt_pkg::LINE_WIDTH_DEF + 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  logic [RES_W-1:0] push_d0,
	input  logic [RES_W-1:0] push_d1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RES_W-1:0] out_data
);

	logic [RES_W-1:0] mem_q [4];
	logic [1:0]       wr_ptr_q;
	logic [1:0]       rd_ptr_q;
	logic [2:0]       count_q;
	logic             pop;

	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= 3'd2) || ((count_q == 3'd3) && pop);
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			count_q  <= count_q + 3'(push_n) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push_d1;
		end
	end

endmodule

// ===== design/map_text_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Map text tokenizer
// An accepted request waits in the input register until its tokens are
// written to the result queue. Throughput: one request per cycle while the
// four-entry result queue has room; it hands out one token at a time.
// Reset clears the input register, the scan state and the result queue.
// ----------------------------------------------------------------------------
module map_text_tokenizer_unit #(
	parameter int OFFSET_WIDTH = mtt_pkg::OFFSET_WIDTH_DEF,
	parameter int LINE_WIDTH   = mtt_pkg::LINE_WIDTH_DEF,
	localparam int TDATA_W     = ((2 * OFFSET_WIDTH + LINE_WIDTH + 8 + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // text_byte
	input  logic               s_axis_tuser,  // kind
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// token_start, token_length, token_line, symbol_code, zero fill
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]         m_axis_tuser,  // token_kind
	output logic               m_axis_tlast
);

	localparam int RES_W = 2 * OFFSET_WIDTH + LINE_WIDTH + 11;

	logic             room;
	logic [1:0]       push_n;
	logic [RES_W-1:0] push_d0;
	logic [RES_W-1:0] push_d1;
	logic [RES_W-1:0] out_data;

	mtt_lexer #(
		.OFFSET_WIDTH(OFFSET_WIDTH),
		.LINE_WIDTH  (LINE_WIDTH),
		.RES_W       (RES_W)
	) u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_end  (s_axis_tuser),
		.in_byte (s_axis_tdata),
		.room    (room),
		.push_n  (push_n),
		.push_d0 (push_d0),
		.push_d1 (push_d1)
	);

	mtt_result_fifo #(
		.RES_W(RES_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push_d0  (push_d0),
		.push_d1  (push_d1),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (out_data)
	);

	assign m_axis_tuser = out_data[1:0];
	assign m_axis_tdata = TDATA_W'(out_data[RES_W-2:2]);
	assign m_axis_tlast = out_data[RES_W-1];

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Map text tokenizer testbench
// Sends short texts byte by byte over the request stream and predicts every
// token from a model of the scanner kept in the testbench. Each token taken
// from the output stream is checked against the oldest prediction. Directed
// texts cover the symbols, lone and embedded slashes, comments, strings with
// line feeds and unterminated tokens at the end of text. Random texts follow
// under changing idle patterns, a long output stall and random noise bytes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int OW          = mtt_pkg::OFFSET_WIDTH_DEF;
	localparam int LW          = mtt_pkg::LINE_WIDTH_DEF;
	localparam int TDATA_W     = ((2 * OW + LW + 8 + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 20;

	localparam logic ITEM_BYTE = 1'b0;
	localparam logic ITEM_END  = 1'b1;

	localparam logic [OW-1:0] POS_MAX  = '1;
	localparam logic [LW-1:0] LINE_MAX = '1;

	typedef enum logic [2:0] {
		SCAN_IDLE    = 3'd0,
		SCAN_SLASH   = 3'd1,
		SCAN_COMMENT = 3'd2,
		SCAN_STRING  = 3'd3,
		SCAN_WORD    = 3'd4
	} scan_mode_t;

	typedef struct packed {
		logic [1:0]    kind;
		logic [OW-1:0] start;
		logic [OW-1:0] length;
		logic [LW-1:0] line;
		logic [7:0]    sym;
		logic          last;
	} token_t;

	logic               clk;
	logic               arst_n        = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata  = 8'h00;
	logic               s_axis_tuser  = ITEM_BYTE;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic [1:0]         m_axis_tuser;
	logic               m_axis_tlast;

	token_t     expected_tokens[$];
	token_t     step_tokens[$];
	token_t     want_tok;
	token_t     got_tok;
	scan_mode_t lex_mode;
	logic [OW-1:0] lex_pos;
	logic [OW-1:0] lex_start;
	logic [LW-1:0] lex_line;
	logic [LW-1:0] lex_open_line;

	int send_idle     = 0;
	int recv_idle     = 0;
	int sent_items    = 0;
	int mismatches    = 0;
	int cycle_count   = 0;
	int hold_left     = 0;
	bit hold_request  = 1'b0;

	map_text_tokenizer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit is_bracket(logic [7:0] c);
		return c == mtt_pkg::CH_LBRACE || c == mtt_pkg::CH_RBRACE ||
			c == mtt_pkg::CH_LPAREN || c == mtt_pkg::CH_RPAREN ||
			c == mtt_pkg::CH_LBRACK || c == mtt_pkg::CH_RBRACK;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == mtt_pkg::CH_SPACE || c == mtt_pkg::CH_TAB ||
			c == mtt_pkg::CH_CR || c == mtt_pkg::CH_LF;
	endfunction

	function automatic logic [OW-1:0] open_length();
		return (lex_pos >= lex_start) ? lex_pos - lex_start : '0;
	endfunction

	task automatic lexer_reset();
		lex_mode      = SCAN_IDLE;
		lex_pos       = '0;
		lex_line      = LW'(1);
		lex_start     = '0;
		lex_open_line = LW'(1);
	endtask

	task automatic emit_token(logic [1:0] k, logic [OW-1:0] st, logic [OW-1:0] len,
			logic [LW-1:0] li, logic [7:0] sy);
		token_t t;
		t = '{kind: k, start: st, length: len, line: li, sym: sy, last: 1'b0};
		step_tokens = {step_tokens, t};
	endtask

	task automatic lex_between(logic [7:0] c);
		lex_mode = SCAN_IDLE;
		if (is_blank(c)) begin
			if (c == mtt_pkg::CH_LF && lex_line < LINE_MAX)
				lex_line++;
		end else if (is_bracket(c)) begin
			emit_token(mtt_pkg::TOK_SYMBOL, lex_pos, OW'(1), lex_line, c);
		end else if (c == mtt_pkg::CH_QUOTE) begin
			lex_start     = (lex_pos < POS_MAX) ? lex_pos + 1'b1 : lex_pos;
			lex_open_line = lex_line;
			lex_mode      = SCAN_STRING;
		end else begin
			lex_start     = lex_pos;
			lex_open_line = lex_line;
			lex_mode      = (c == mtt_pkg::CH_SLASH) ? SCAN_SLASH : SCAN_WORD;
		end
	endtask

	task automatic lex_word(logic [7:0] c);
		if (is_blank(c) || is_bracket(c)) begin
			emit_token(mtt_pkg::TOK_WORD, lex_start, open_length(), lex_open_line, 8'h00);
			lex_between(c);
		end else begin
			lex_mode = SCAN_WORD;
		end
	endtask

	task automatic predict_tokens(logic k, logic [7:0] c);
		step_tokens.delete();
		if (k == ITEM_END) begin
			if (lex_mode == SCAN_SLASH || lex_mode == SCAN_WORD)
				emit_token(mtt_pkg::TOK_WORD, lex_start, open_length(), lex_open_line,
					8'h00);
			else if (lex_mode == SCAN_STRING)
				emit_token(mtt_pkg::TOK_STRING, lex_start, open_length(), lex_open_line,
					8'h00);
			emit_token(mtt_pkg::TOK_END, lex_pos, '0, lex_line, 8'h00);
			lexer_reset();
		end else begin
			case (lex_mode)
				SCAN_SLASH: begin
					if (c == mtt_pkg::CH_SLASH)
						lex_mode = SCAN_COMMENT;
					else
						lex_word(c);
				end
				SCAN_COMMENT: begin
					if (c == mtt_pkg::CH_LF)
						lex_between(c);
				end
				SCAN_STRING: begin
					if (c == mtt_pkg::CH_QUOTE) begin
						emit_token(mtt_pkg::TOK_STRING, lex_start, open_length(),
							lex_open_line, 8'h00);
						lex_mode = SCAN_IDLE;
					end else if (c == mtt_pkg::CH_LF && lex_line < LINE_MAX) begin
						lex_line++;
					end
				end
				SCAN_WORD: lex_word(c);
				default: lex_between(c);
			endcase
			if (lex_pos < POS_MAX)
				lex_pos++;
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		expected_tokens = {expected_tokens, step_tokens};
	endtask

	task automatic send_request(logic k, logic [7:0] c);
		while ($urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tuser  <= k;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_tokens(k, c);
		sent_items++;
	endtask

	task automatic send_bytes(string s);
		foreach (s[i])
			send_request(ITEM_BYTE, s[i]);
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_tokens.size() > 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] word_byte(bit first);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_blank(c) || is_bracket(c) ||
			(first && (c == mtt_pkg::CH_QUOTE || c == mtt_pkg::CH_SLASH)));
		return c;
	endfunction

	function automatic logic [7:0] bracket_byte();
		case ($urandom_range(0, 5))
			0: return mtt_pkg::CH_LBRACE;
			1: return mtt_pkg::CH_RBRACE;
			2: return mtt_pkg::CH_LPAREN;
			3: return mtt_pkg::CH_RPAREN;
			4: return mtt_pkg::CH_LBRACK;
			default: return mtt_pkg::CH_RBRACK;
		endcase
	endfunction

	function automatic logic [7:0] blank_byte();
		case ($urandom_range(0, 3))
			0: return mtt_pkg::CH_SPACE;
			1: return mtt_pkg::CH_TAB;
			2: return mtt_pkg::CH_CR;
			default: return mtt_pkg::CH_LF;
		endcase
	endfunction

	task automatic send_random_text(int pieces);
		int pick;
		int len;
		logic [7:0] c;
		repeat (pieces) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				send_request(ITEM_BYTE, bracket_byte());
			end else if (pick < 35) begin
				repeat ($urandom_range(1, 3))
					send_request(ITEM_BYTE, blank_byte());
			end else if (pick < 60) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_request(ITEM_BYTE, word_byte(i == 0));
			end else if (pick < 75) begin
				send_request(ITEM_BYTE, mtt_pkg::CH_QUOTE);
				repeat ($urandom_range(0, 8)) begin
					if ($urandom_range(0, 3) == 0) begin
						c = mtt_pkg::CH_LF;
					end else begin
						do
							c = 8'($urandom_range(0, 255));
						while (c == mtt_pkg::CH_QUOTE);
					end
					send_request(ITEM_BYTE, c);
				end
				if ($urandom_range(0, 4) != 0)
					send_request(ITEM_BYTE, mtt_pkg::CH_QUOTE);
			end else if (pick < 83) begin
				send_bytes("//");
				repeat ($urandom_range(0, 6)) begin
					do
						c = 8'($urandom_range(0, 255));
					while (c == mtt_pkg::CH_LF);
					send_request(ITEM_BYTE, c);
				end
				send_request(ITEM_BYTE, mtt_pkg::CH_LF);
			end else if (pick < 90) begin
				send_request(ITEM_BYTE, mtt_pkg::CH_SLASH);
				if ($urandom_range(0, 1))
					send_request(ITEM_BYTE, word_byte(1'b1));
				else
					send_request(ITEM_BYTE, bracket_byte());
			end else begin
				send_request(ITEM_BYTE, 8'($urandom_range(0, 255)));
			end
		end
		send_request(ITEM_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_symbols_and_slash();
		send_bytes("/{}()[]");
		send_request(ITEM_END, 8'h00);
	endtask

	task automatic test_words_and_lone_slash();
		send_request(ITEM_BYTE, 8'h00);
		send_request(ITEM_BYTE, mtt_pkg::CH_SLASH);
		send_request(ITEM_BYTE, mtt_pkg::CH_QUOTE);
		send_request(ITEM_BYTE, 8'hFF);
		send_request(ITEM_BYTE, mtt_pkg::CH_RPAREN);
		send_request(ITEM_BYTE, mtt_pkg::CH_SPACE);
		send_request(ITEM_BYTE, mtt_pkg::CH_SLASH);
		send_request(ITEM_END, 8'hFF);
	endtask

	task automatic test_comment_and_strings();
		send_bytes("//c\n\"x\ny");
		send_request(ITEM_END, 8'h5A);
	endtask

	task automatic test_random_text(int send_pct, int recv_pct, int count);
		int target;
		send_idle = send_pct;
		recv_idle = recv_pct;
		target    = sent_items + count;
		while (sent_items < target) begin
			send_random_text($urandom_range(1, 12));
			if ($urandom_range(0, 7) == 0)
				wait_drain();
		end
	endtask

	task automatic test_random_noise(int count);
		repeat (count) begin
			if ($urandom_range(0, 39) == 0)
				send_request(ITEM_END, 8'($urandom_range(0, 255)));
			else
				send_request(ITEM_BYTE, 8'($urandom_range(0, 255)));
		end
		send_request(ITEM_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_output_stall();
		wait_drain();
		send_idle    = 0;
		hold_request = 1'b1;
		send_bytes("{a}(b)[c]{}()[]");
		send_random_text(30);
		wait_drain();
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	function automatic string tok_text(token_t t);
		return $sformatf("kind=%0d start=%0d len=%0d line=%0d sym=%02h last=%0b",
			t.kind, t.start, t.length, t.line, t.sym, t.last);
	endfunction

	task automatic note_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %s, got %s", what, tok_text(want_tok),
				tok_text(got_tok));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_tok.kind   = m_axis_tuser;
			got_tok.start  = m_axis_tdata[OW-1:0];
			got_tok.length = m_axis_tdata[2*OW-1:OW];
			got_tok.line   = m_axis_tdata[2*OW+LW-1:2*OW];
			got_tok.sym    = m_axis_tdata[2*OW+LW+7:2*OW+LW];
			got_tok.last   = m_axis_tlast;
			if (expected_tokens.size() == 0) begin
				want_tok = '0;
				note_mismatch("unexpected token");
			end else begin
				want_tok = expected_tokens.pop_front();
				if (got_tok !== want_tok)
					note_mismatch("token mismatch");
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		lexer_reset();
		send_idle = 33;
		recv_idle = 85;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_symbols_and_slash();
		test_words_and_lone_slash();
		test_comment_and_strings();
		wait_drain();

		test_random_text(33, 85, 280);
		test_random_text(85, 33, 280);
		test_random_noise(80);
		wait_drain();
		test_random_text(0, 0, 220);
		test_output_stall();

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
